[hw/rtl/askx_pkg.sv]
// ----------------------------------------------------------------------------
// askx_pkg
// Shared constants, register indexes and LFSR step function for the
// alternating-step keystream XOR block.
// ----------------------------------------------------------------------------
package askx_pkg;

  localparam int unsigned LenADefault = 32;
  localparam int unsigned LenBDefault = 30;
  localparam int unsigned LenCDefault = 28;

  localparam logic [31:0] DefSeedA = 32'h1357_9BDF;
  localparam logic [31:0] DefSeedB = 32'h2468_ACE0;
  localparam logic [31:0] DefSeedC = 32'hFDB9_7531;

  localparam logic [31:0] FbAReset = 32'h8000_0062;
  localparam logic [31:0] FbBReset = 32'h4000_0020;
  localparam logic [31:0] FbCReset = 32'h1000_0002;

  // keystream bits per byte: four bits per round, two rounds
  localparam int unsigned KsRounds = 2;
  localparam int unsigned KsBits   = 4 * KsRounds;

  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SEED_A     = 3'd0,
    REG_SEED_B     = 3'd1,
    REG_SEED_C     = 3'd2,
    REG_FEEDBACK_A = 3'd3,
    REG_FEEDBACK_B = 3'd4,
    REG_FEEDBACK_C = 3'd5
  } cfg_reg_t;

  // One Galois step with length mask km; the or-mask is ~km.
  function automatic logic [31:0] galois_step(input logic [31:0] r,
                                              input logic [31:0] fb,
                                              input logic [31:0] km);
    if (!r[0]) begin
      return (r >> 1) & km;
    end else begin
      return ((r ^ fb) >> 1) | ~km;
    end
  endfunction

  // A zero seed falls back to its default.
  function automatic logic [31:0] pick_seed(input logic [31:0] seed,
                                            input logic [31:0] dflt);
    return (seed == '0) ? dflt : seed;
  endfunction

endpackage

[hw/rtl/alternating_step_keystream_xor.sv]
// An input transaction passes the input register, then the result register.
// Throughput: one byte per cycle unless a stalled result holds the pipeline;
// the eight LFSR steps of a byte are unrolled between those two registers.
// Reset: config registers return to their reset values, the three LFSRs load
// the default seeds and both pipeline registers empty.
// ----------------------------------------------------------------------------
// alternating_step_keystream_xor
// XORs each byte with a keystream byte from three Galois LFSRs stepped in
// alternating-step fashion; a zero result is replaced by the keystream byte.
// ----------------------------------------------------------------------------
module alternating_step_keystream_xor #(
  parameter int unsigned LEN_A = askx_pkg::LenADefault,
  parameter int unsigned LEN_B = askx_pkg::LenBDefault,
  parameter int unsigned LEN_C = askx_pkg::LenCDefault
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [7:0]                   in_byte,
  input  logic                         restart,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [7:0]                   out_byte,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [askx_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [31:0]                  cfg_data
);

  localparam logic [31:0] KeepA = (32'd1 << (LEN_A - 1)) - 32'd1;
  localparam logic [31:0] KeepB = (32'd1 << (LEN_B - 1)) - 32'd1;
  localparam logic [31:0] KeepC = (32'd1 << (LEN_C - 1)) - 32'd1;

  logic [31:0] seed_a, seed_b, seed_c;
  logic [31:0] feedback_a, feedback_b, feedback_c;
  logic [31:0] lfsr_a, lfsr_b, lfsr_c;
  logic [31:0] lfsr_a_next, lfsr_b_next, lfsr_c_next;

  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_restart;
  logic        advance;
  logic [7:0]  ks;
  logic [7:0]  out_byte_next;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || !out_stall;
  assign in_stall  = s1_valid && !advance;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      seed_a     <= askx_pkg::DefSeedA;
      seed_b     <= askx_pkg::DefSeedB;
      seed_c     <= askx_pkg::DefSeedC;
      feedback_a <= askx_pkg::FbAReset;
      feedback_b <= askx_pkg::FbBReset;
      feedback_c <= askx_pkg::FbCReset;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        askx_pkg::REG_SEED_A:     seed_a     <= cfg_data;
        askx_pkg::REG_SEED_B:     seed_b     <= cfg_data;
        askx_pkg::REG_SEED_C:     seed_c     <= cfg_data;
        askx_pkg::REG_FEEDBACK_A: feedback_a <= cfg_data;
        askx_pkg::REG_FEEDBACK_B: feedback_b <= cfg_data;
        askx_pkg::REG_FEEDBACK_C: feedback_c <= cfg_data;
        default: ;
      endcase
    end
  end

  // keystream byte: eight unrolled alternating steps
  always_comb begin
    logic [31:0] a, b, c;
    logic        hb, hc, pick;
    a  = s1_restart ? askx_pkg::pick_seed(seed_a, askx_pkg::DefSeedA) : lfsr_a;
    b  = s1_restart ? askx_pkg::pick_seed(seed_b, askx_pkg::DefSeedB) : lfsr_b;
    c  = s1_restart ? askx_pkg::pick_seed(seed_c, askx_pkg::DefSeedC) : lfsr_c;
    hb = b[0];
    hc = c[0];
    ks = '0;
    for (int i = 0; i < askx_pkg::KsBits; i++) begin
      pick = a[0];
      a    = askx_pkg::galois_step(a, feedback_a, KeepA);
      if (pick) begin
        hb = b[0];
        b  = askx_pkg::galois_step(b, feedback_b, KeepB);
      end else begin
        hc = c[0];
        c  = askx_pkg::galois_step(c, feedback_c, KeepC);
      end
      ks = {ks[6:0], hb ^ hc};
    end
    lfsr_a_next   = a;
    lfsr_b_next   = b;
    lfsr_c_next   = c;
    out_byte_next = ((s1_byte ^ ks) == 8'd0) ? ks : (s1_byte ^ ks);
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte    <= in_byte;
      s1_restart <= restart;
    end
  end

  // LFSR state moves on when a byte leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr_a <= askx_pkg::DefSeedA;
      lfsr_b <= askx_pkg::DefSeedB;
      lfsr_c <= askx_pkg::DefSeedC;
    end else if (s1_valid && advance) begin
      lfsr_a <= lfsr_a_next;
      lfsr_b <= lfsr_b_next;
      lfsr_c <= lfsr_c_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && advance) begin
      out_byte <= out_byte_next;
    end
  end

endmodule

[hw/rtl/askx_checker.sv]
// ----------------------------------------------------------------------------
// askx_checker
// Port-level checks on the keystream XOR block, bound to the top level.
// ----------------------------------------------------------------------------
module askx_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte))
    else $error("stalled result changed");

  // input only backs up when the result register is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output free");

  // after an accepted byte, the result register holds a valid result
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |-> ##2 out_valid)
    else $error("accepted byte did not reach output");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind alternating_step_keystream_xor askx_checker u_askx_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_byte  (out_byte)
);

[verif/alternating_step_keystream_xor_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// alternating_step_keystream_xor_tb
// Self-checking bench for the alternating-step keystream XOR block. A
// byte-level model of the three LFSRs predicts every output byte. Random
// sender gaps and receiver stalls run across several key and feedback settings.
// ----------------------------------------------------------------------------
module alternating_step_keystream_xor_tb;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned LongHold   = 150;
  // indexes past the register map; writes there must be dropped
  localparam logic [askx_pkg::CfgIdxW-1:0] RegSpareLo = 3'd6;
  localparam logic [askx_pkg::CfgIdxW-1:0] RegSpareHi = 3'd7;

  typedef struct packed {
    logic [7:0] text;
    logic       rs;
  } byte_item_t;

  typedef struct {
    logic [31:0] seed_a, seed_b, seed_c;
    logic [31:0] fb_a, fb_b, fb_c;
    logic [31:0] reg_a, reg_b, reg_c;
  } cipher_state_t;

  logic                         clk       = 1'b0;
  logic                         rst       = 1'b1;
  logic                         in_valid  = 1'b0;
  logic                         in_stall;
  logic [7:0]                   in_byte   = '0;
  logic                         restart   = 1'b0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [7:0]                   out_byte;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [askx_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [31:0]                  cfg_data  = '0;

  cipher_state_t model;   // advanced on accepted transactions
  cipher_state_t plan;    // advanced as items are queued
  byte_item_t    pending[$];
  logic [7:0]    want_bytes[$];

  int unsigned cycle_count  = 0;
  int unsigned mismatches   = 0;
  int unsigned queued       = 0;
  int unsigned accepted     = 0;
  int unsigned delivered    = 0;
  int unsigned restarts     = 0;
  int unsigned cfg_writes   = 0;
  int unsigned subs_planned = 0;
  int unsigned idle_pct     = 0;
  int unsigned stall_pct    = 0;
  int unsigned gap_left     = 0;
  int unsigned stall_left   = 0;
  int unsigned hold_left    = 0;
  bit          hold_ask     = 1'b0;
  bit          in_sent      = 1'b0;

  alternating_step_keystream_xor u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .restart   (restart),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic [31:0] galois_next(input logic [31:0] r,
                                              input logic [31:0] fb,
                                              input int unsigned len);
    logic [31:0] keep;
    keep = (32'd1 << (len - 1)) - 32'd1;
    return r[0] ? (((r ^ fb) >> 1) | ~keep) : ((r >> 1) & keep);
  endfunction

  function automatic void load_keys(inout cipher_state_t st);
    st.reg_a = (st.seed_a == '0) ? askx_pkg::DefSeedA : st.seed_a;
    st.reg_b = (st.seed_b == '0) ? askx_pkg::DefSeedB : st.seed_b;
    st.reg_c = (st.seed_c == '0) ? askx_pkg::DefSeedC : st.seed_c;
  endfunction

  function automatic cipher_state_t fresh_state();
    cipher_state_t st;
    st.seed_a = askx_pkg::DefSeedA;
    st.seed_b = askx_pkg::DefSeedB;
    st.seed_c = askx_pkg::DefSeedC;
    st.fb_a   = askx_pkg::FbAReset;
    st.fb_b   = askx_pkg::FbBReset;
    st.fb_c   = askx_pkg::FbCReset;
    load_keys(st);
    return st;
  endfunction

  function automatic void apply_cfg(inout cipher_state_t st,
                                    input logic [askx_pkg::CfgIdxW-1:0] idx,
                                    input logic [31:0] val);
    case (askx_pkg::cfg_reg_t'(idx))
      askx_pkg::REG_SEED_A:     st.seed_a = val;
      askx_pkg::REG_SEED_B:     st.seed_b = val;
      askx_pkg::REG_SEED_C:     st.seed_c = val;
      askx_pkg::REG_FEEDBACK_A: st.fb_a   = val;
      askx_pkg::REG_FEEDBACK_B: st.fb_b   = val;
      askx_pkg::REG_FEEDBACK_C: st.fb_c   = val;
      default: ;
    endcase
  endfunction

  // Runs one byte through the generator: A always steps, its old low bit
  // picks B or C. Held bits restart from B/C low bits each byte.
  function automatic logic [7:0] cipher_byte(inout cipher_state_t st,
                                             input logic [7:0] text,
                                             input logic rs);
    logic [7:0] key;
    logic       bit_b, bit_c, sel;
    key = '0;
    if (rs) begin
      load_keys(st);
    end
    bit_b = st.reg_b[0];
    bit_c = st.reg_c[0];
    for (int i = 0; i < askx_pkg::KsBits; i++) begin
      sel      = st.reg_a[0];
      st.reg_a = galois_next(st.reg_a, st.fb_a, askx_pkg::LenADefault);
      if (sel) begin
        bit_b    = st.reg_b[0];
        st.reg_b = galois_next(st.reg_b, st.fb_b, askx_pkg::LenBDefault);
      end else begin
        bit_c    = st.reg_c[0];
        st.reg_c = galois_next(st.reg_c, st.fb_c, askx_pkg::LenCDefault);
      end
      key = {key[6:0], bit_b ^ bit_c};
    end
    return ((text ^ key) == '0) ? key : (text ^ key);
  endfunction

  // Keystream of the next queued byte; with zero text the result is the key.
  function automatic logic [7:0] next_key(input logic rs);
    cipher_state_t probe;
    probe = plan;
    return cipher_byte(probe, 8'h00, rs);
  endfunction

  task automatic push_item(input logic [7:0] text, input logic rs);
    byte_item_t it;
    it.text = text;
    it.rs   = rs;
    void'(cipher_byte(plan, text, rs));
    pending.insert(pending.size(), it);
    queued++;
  endtask

  task automatic run_random(input int count);
    logic       rs;
    logic [7:0] key;
    repeat (count) begin
      rs  = ($urandom_range(0, 39) == 0);
      key = next_key(rs);
      if ($urandom_range(0, 15) == 0) begin
        push_item(key, rs);
        subs_planned++;
      end else begin
        push_item(8'($urandom()), rs);
      end
    end
  endtask

  task automatic cfg_write(input logic [askx_pkg::CfgIdxW-1:0] idx,
                           input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait until everything queued has come back, then resync the planner.
  task automatic settle();
    do @(negedge clk); while (accepted != queued || want_bytes.size() != 0);
    repeat (4) @(negedge clk);
    plan = model;
  endtask

  // sender
  always @(negedge clk) begin
    if (!in_valid || in_sent) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
        gap_left = $urandom_range(0, 11);
        in_valid <= 1'b0;
      end else if (!rst && pending.size() > 0) begin
        in_byte  <= pending[0].text;
        restart  <= pending[0].rs;
        in_valid <= 1'b1;
        void'(pending.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
      in_sent = 1'b0;
    end
  end

  // receiver
  always @(negedge clk) begin
    if (hold_ask) begin
      hold_ask  = 1'b0;
      hold_left = LongHold;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(0, 11);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    if (rst) begin
      model = fresh_state();
      want_bytes.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        apply_cfg(model, cfg_index, cfg_data);
        cfg_writes++;
      end
      if (in_valid && !in_stall) begin
        want_bytes.insert(want_bytes.size(), cipher_byte(model, in_byte, restart));
        in_sent = 1'b1;
        accepted++;
        if (restart) restarts++;
      end
      if (out_valid && !out_stall) begin
        delivered++;
        if (want_bytes.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected out_byte transaction, expected none, got %02h",
                   $time, out_byte);
        end else begin
          if (out_byte !== want_bytes[0]) begin
            mismatches++;
            $display("%0t: out_byte mismatch, expected %02h, got %02h",
                     $time, want_bytes[0], out_byte);
          end
          void'(want_bytes.pop_front());
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("%0t: timeout, %0d of %0d bytes accepted, %0d results pending",
               $time, accepted, queued, want_bytes.size());
      $display("alternating_step_keystream_xor verification failed");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    settle();

    // directed: field extremes, restart, text equal to keystream
    idle_pct  = 20;
    stall_pct = 20;
    push_item(8'h00, 1'b0);
    push_item(8'hFF, 1'b0);
    push_item(8'h80, 1'b0);
    push_item(8'h01, 1'b0);
    push_item(8'h55, 1'b1);
    push_item(8'hAA, 1'b0);
    push_item(next_key(1'b0), 1'b0);
    push_item(next_key(1'b1), 1'b1);
    push_item(8'hFF, 1'b1);
    push_item(8'h00, 1'b1);
    push_item(8'h7F, 1'b0);
    push_item(8'hFE, 1'b0);
    subs_planned += 2;
    run_random(300);
    settle();

    // all-ones keys, zero feedback, stray writes past the map
    cfg_write(RegSpareLo, $urandom());
    cfg_write(RegSpareHi, $urandom());
    cfg_write(askx_pkg::REG_SEED_A, '1);
    cfg_write(askx_pkg::REG_SEED_B, '1);
    cfg_write(askx_pkg::REG_SEED_C, '1);
    cfg_write(askx_pkg::REG_FEEDBACK_A, '0);
    cfg_write(askx_pkg::REG_FEEDBACK_B, '0);
    cfg_write(askx_pkg::REG_FEEDBACK_C, '0);
    settle();
    idle_pct  = 8;
    stall_pct = 30;
    push_item(8'($urandom()), 1'b1);
    run_random(250);
    settle();

    // zero keys fall back to defaults; all-ones feedback; long output hold
    cfg_write(askx_pkg::REG_SEED_A, '0);
    cfg_write(askx_pkg::REG_SEED_B, '0);
    cfg_write(askx_pkg::REG_SEED_C, '0);
    cfg_write(askx_pkg::REG_FEEDBACK_A, '1);
    cfg_write(askx_pkg::REG_FEEDBACK_B, '1);
    cfg_write(askx_pkg::REG_FEEDBACK_C, '1);
    settle();
    idle_pct  = 0;
    stall_pct = 10;
    push_item(8'($urandom()), 1'b1);
    run_random(250);
    hold_ask = 1'b1;
    settle();

    // new keys only apply at restart; new feedback applies at once
    cfg_write(askx_pkg::REG_SEED_A, $urandom());
    cfg_write(askx_pkg::REG_SEED_B, $urandom());
    cfg_write(askx_pkg::REG_SEED_C, $urandom());
    cfg_write(askx_pkg::REG_FEEDBACK_B, $urandom());
    settle();
    idle_pct  = 30;
    stall_pct = 15;
    repeat (6) push_item(8'($urandom()), 1'b0);
    push_item(8'($urandom()), 1'b1);
    run_random(350);
    settle();

    cfg_write(askx_pkg::REG_FEEDBACK_A, $urandom());
    cfg_write(askx_pkg::REG_FEEDBACK_C, $urandom());
    cfg_write(askx_pkg::REG_SEED_C, $urandom());
    settle();
    idle_pct  = 15;
    stall_pct = 40;
    run_random(350);
    settle();

    // back to reset settings, full rate both sides
    cfg_write(askx_pkg::REG_SEED_A, askx_pkg::DefSeedA);
    cfg_write(askx_pkg::REG_SEED_B, askx_pkg::DefSeedB);
    cfg_write(askx_pkg::REG_SEED_C, askx_pkg::DefSeedC);
    cfg_write(askx_pkg::REG_FEEDBACK_A, askx_pkg::FbAReset);
    cfg_write(askx_pkg::REG_FEEDBACK_B, askx_pkg::FbBReset);
    cfg_write(askx_pkg::REG_FEEDBACK_C, askx_pkg::FbCReset);
    settle();
    idle_pct  = 0;
    stall_pct = 0;
    push_item(8'($urandom()), 1'b1);
    run_random(400);
    settle();
    repeat (10) @(negedge clk);

    $display("Run covered %0d bytes in, %0d out, %0d restarts, %0d register writes,",
             accepted, delivered, restarts, cfg_writes);
    $display("%0d bytes forced to match the keystream, %0d mismatches.",
             subs_planned, mismatches);
    if (mismatches == 0) begin
      $display("alternating_step_keystream_xor verification clean");
    end else begin
      $display("alternating_step_keystream_xor verification failed");
    end
    $finish;
  end

endmodule
